FILE: rtl/dff_pkg.sv
package dff_pkg;

   localparam int LINE_MAX = 19;
   localparam int LEN_W    = 5;
   localparam int DIGIT_W  = 4;
   localparam int REM_W    = 10;

   // Largest value shown as digits; anything above shows stars.
   localparam logic [31:0] LIMIT_VALUE = 32'd9999;

   // Format codes
   localparam logic [1:0] OP_RAW     = 2'd0;
   localparam logic [1:0] OP_VOLTAGE = 2'd1;
   localparam logic [1:0] OP_PERCENT = 2'd2;
   localparam logic [1:0] OP_PWM     = 2'd3;

   typedef logic [7:0] char_type;
   typedef logic [LINE_MAX-1:0][7:0] line_type;

   localparam char_type ASCII_ZERO = 8'h30;
   localparam char_type STAR_CHAR  = 8'h2A;
   localparam char_type SPACE_CHAR = 8'h20;
   localparam char_type DOT_CHAR   = 8'h2E;
   localparam char_type PCT_CHAR   = 8'h25;
   localparam char_type V_CHAR     = 8'h56;

   localparam int LABEL_RAW_LEN  = 5;
   localparam int LABEL_VOLT_LEN = 9;
   localparam int LABEL_PCT_LEN  = 9;
   localparam int LABEL_PWM_LEN  = 10;

   localparam char_type LABEL_RAW [LABEL_RAW_LEN] = '{"R", "a", "w", ":", " "};
   localparam char_type LABEL_VOLT [LABEL_VOLT_LEN] =
      '{"V", "o", "l", "t", "a", "g", "e", ":", " "};
   localparam char_type LABEL_PCT [LABEL_PCT_LEN] =
      '{"P", "e", "r", "c", "e", "n", "t", ":", " "};
   localparam char_type LABEL_PWM [LABEL_PWM_LEN] =
      '{"P", "W", "M", " ", "d", "u", "t", "y", ":", " "};

   localparam logic [LEN_W-1:0] LEN_RAW     = 5'd9;
   localparam logic [LEN_W-1:0] LEN_VOLTAGE = 5'd16;
   localparam logic [LEN_W-1:0] LEN_PERCENT = 5'd18;
   localparam logic [LEN_W-1:0] LEN_PWM     = 5'd19;

   typedef struct packed {
      logic               over;
      logic [DIGIT_W-1:0] thou;
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } digits_type;

endpackage

FILE: rtl/dff_digits.sv
module dff_digits import dff_pkg::*; (
   input  logic [REM_W-1:0]   rem,
   output logic [DIGIT_W-1:0] hund,
   output logic [DIGIT_W-1:0] tens,
   output logic [DIGIT_W-1:0] ones
);

   logic [15:0] hund_prod;
   logic [9:0]  hund_back;
   logic [9:0]  rem100;
   logic [13:0] tens_prod;
   logic [6:0]  tens_back;
   logic [6:0]  rem10;

   // rem < 1000: n/100 == (n*41)>>12, then n/10 == (n*103)>>10 for n < 100
   always_comb begin
      hund_prod = 16'(rem) * 16'd41;
      hund      = hund_prod[15:12];
      hund_back = 10'(hund) * 10'd100;
      rem100    = rem - hund_back;
      tens_prod = 14'(rem100[6:0]) * 14'd103;
      tens      = tens_prod[13:10];
      tens_back = 7'(tens) * 7'd10;
      rem10     = rem100[6:0] - tens_back;
      ones      = rem10[DIGIT_W-1:0];
   end

endmodule

FILE: rtl/dff_line_build.sv
module dff_line_build import dff_pkg::*; (
   input  digits_type       digits,
   input  logic [1:0]       opcode,
   output line_type         line,
   output logic [LEN_W-1:0] len
);

   char_type ch_thou;
   char_type ch_hund;
   char_type ch_tens;
   char_type ch_ones;
   char_type pct_thou;
   char_type pct_hund;
   logic     blank_thou;

   always_comb begin
      ch_thou = digits.over ? STAR_CHAR : (ASCII_ZERO | char_type'(digits.thou));
      ch_hund = digits.over ? STAR_CHAR : (ASCII_ZERO | char_type'(digits.hund));
      ch_tens = digits.over ? STAR_CHAR : (ASCII_ZERO | char_type'(digits.tens));
      ch_ones = digits.over ? STAR_CHAR : (ASCII_ZERO | char_type'(digits.ones));

      // blank leading zeros of the percent layout only
      blank_thou = !digits.over && (digits.thou == '0);
      pct_thou   = blank_thou ? SPACE_CHAR : ch_thou;
      pct_hund   = (blank_thou && digits.hund == '0) ? SPACE_CHAR : ch_hund;
   end

   always_comb begin
      line = {LINE_MAX{SPACE_CHAR}};
      len  = LEN_RAW;
      unique case (opcode)
         OP_RAW: begin
            for (int i = 0; i < LABEL_RAW_LEN; i++) line[i] = LABEL_RAW[i];
            line[5] = ch_thou;
            line[6] = ch_hund;
            line[7] = ch_tens;
            line[8] = ch_ones;
            len     = LEN_RAW;
         end
         OP_VOLTAGE: begin
            for (int i = 0; i < LABEL_VOLT_LEN; i++) line[i] = LABEL_VOLT[i];
            line[9]  = ch_thou;
            line[10] = DOT_CHAR;
            line[11] = ch_hund;
            line[12] = ch_tens;
            line[13] = ch_ones;
            line[14] = SPACE_CHAR;
            line[15] = V_CHAR;
            len      = LEN_VOLTAGE;
         end
         OP_PERCENT: begin
            for (int i = 0; i < LABEL_PCT_LEN; i++) line[i] = LABEL_PCT[i];
            line[9]  = pct_thou;
            line[10] = pct_hund;
            line[11] = ch_tens;
            line[12] = DOT_CHAR;
            line[13] = ch_ones;
            line[14] = SPACE_CHAR;
            line[15] = PCT_CHAR;
            line[16] = SPACE_CHAR;
            line[17] = SPACE_CHAR;
            len      = LEN_PERCENT;
         end
         OP_PWM: begin
            for (int i = 0; i < LABEL_PWM_LEN; i++) line[i] = LABEL_PWM[i];
            line[10] = ch_thou;
            line[11] = ch_hund;
            line[12] = ch_tens;
            line[13] = DOT_CHAR;
            line[14] = ch_ones;
            line[15] = SPACE_CHAR;
            line[16] = PCT_CHAR;
            line[17] = SPACE_CHAR;
            line[18] = SPACE_CHAR;
            len      = LEN_PWM;
         end
         default: begin
            len = LEN_RAW;
         end
      endcase
   end

endmodule

FILE: rtl/decimal_field_formatter_core.sv
// Decimal field formatter. Each word (value, opcode) becomes one ASCII line that
// leaves on rsp_character one character per cycle, rsp_strobe high on every
// character and rsp_last on the final one; the receiver cannot stall, so take
// each character in the cycle it is shown. Lines are 9 (raw), 16 (voltage),
// 18 (percent) or 19 (pwm duty) characters, and a value above 9999 shows '*'
// in every digit position. A word is taken when start is high and busy is low.
// busy is high while the input register holds a word that has not yet moved
// into the output shift register; that move happens when the shift register
// is empty or shows its last character, so consecutive lines leave with no gap
// and a new word can be taken while the previous line is still leaving. With
// the block idle, an accepted word is registered first in the input register
// and then in the output shift register, which then shows its first character.
// The output shift register, emptying one character per cycle, sets the pace
// at which words are taken.
module decimal_field_formatter_core import dff_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_opcode,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               over_ff;
   logic [DIGIT_W-1:0] thou_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [1:0]         op_ff;

   // output shift register
   line_type           line_ff, line_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;

   logic               accept;
   logic               load;
   logic [27:0]        thou_prod;
   logic [DIGIT_W-1:0] thou_new;
   logic [13:0]        rem_new;
   logic [DIGIT_W-1:0] digit_hund;
   logic [DIGIT_W-1:0] digit_tens;
   logic [DIGIT_W-1:0] digit_ones;
   digits_type         digits;
   line_type           line_new;
   logic [LEN_W-1:0]   len_new;

   assign busy   = in_valid_ff;
   assign accept = start && !in_valid_ff;
   // move the held word out when the shift register is empty or on its last character
   assign load   = in_valid_ff && (cnt_ff == '0 || cnt_ff == LEN_W'(1));

   // split off the thousands digit on the way in: v/1000 == (v*8389)>>23 for v < 10000
   always_comb begin
      thou_prod = 28'(req_value[13:0]) * 28'd8389;
      thou_new  = thou_prod[26:23];
      rem_new   = req_value[13:0] - (14'(thou_new) * 14'd1000);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         over_ff <= req_value > LIMIT_VALUE;
         thou_ff <= thou_new;
         rem_ff  <= rem_new[REM_W-1:0];
         op_ff   <= req_opcode;
      end
   end

   dff_digits u_digits (
      .rem  (rem_ff),
      .hund (digit_hund),
      .tens (digit_tens),
      .ones (digit_ones)
   );

   assign digits = '{over: over_ff, thou: thou_ff, hund: digit_hund,
                     tens: digit_tens, ones: digit_ones};

   dff_line_build u_line_build (
      .digits (digits),
      .opcode (op_ff),
      .line   (line_new),
      .len    (len_new)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // load a fresh line, or advance one character
   always_comb begin
      line_in = line_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         line_in = line_new;
         cnt_in  = len_new;
      end else if (cnt_ff != '0) begin
         line_in = line_ff >> 8;
         cnt_in  = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   assign rsp_strobe    = cnt_ff != '0;
   assign rsp_character = line_ff[0];
   assign rsp_last      = cnt_ff == LEN_W'(1);

   // a line leaves without gaps until its last character
   a_line_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("line broke off before its last character");

   // a held word moves out at once when the shift register is idle
   a_idle_load: assert property (@(posedge clock) disable iff (reset)
      busy && !rsp_strobe |=> rsp_strobe && !busy)
      else $error("held word not loaded into idle shift register");

   // a held word follows its predecessor's last character with no gap
   a_back_to_back: assert property (@(posedge clock) disable iff (reset)
      busy && rsp_last |=> rsp_strobe && !busy)
      else $error("held word did not follow the last character");

   // an accepted word raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word not held");

endmodule
